/* design/tpi_pkg.sv */
// Package with shared constants, types and state codes of the track point interpolator.
`default_nettype none
package tpi_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PT_W       = 96;
    localparam logic [23:0] SECOND_MAX = 24'hFFFFFF;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
    } point_t;

    typedef struct packed {
        logic [23:0] elapsed_seconds;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic        past_end;
        logic        final_tick;
    } result_t;

    typedef struct packed {
        logic        command;
        logic [31:0] point_time;
        logic [31:0] point_x;
        logic [31:0] point_y;
    } item_t;

    // Controls between the sequencer and the lerp unit.
    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] num;
        logic [31:0] den;
    } lerp_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LSCAN,
        ST_LCHK,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_TRD,
        ST_TCHK,
        ST_LX,
        ST_LY,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

/* design/tpi_stream_if.sv */
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface tpi_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/tpi_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module tpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* design/tpi_lerp.sv */
// Iterative a + round((b - a) * num / den) unit with a shift-add multiply and restoring divide.
`default_nettype none
module tpi_lerp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tpi_pkg::lerp_req_t req,
    output logic                    done,
    output logic [31:0]             res
);
    import tpi_pkg::*;

    logic [5:0]  cnt_reg, cnt_next;
    logic [1:0]  ph_reg, ph_next;
    logic [64:0] acc_reg, acc_next;
    logic [32:0] mag_reg, mag_next;
    logic [31:0] mul_reg, mul_next;
    logic [31:0] den_reg, den_next;
    logic [64:0] rem_reg, rem_next;
    logic [64:0] quo_reg, quo_next;
    logic        neg_reg, neg_next;
    logic [31:0] a_reg, a_next;
    logic        done_reg, done_next;
    logic [32:0] d;
    logic [65:0] trial;
    logic [31:0] sum;

    always_comb
    begin
        d = {req.b[31], req.b} - {req.a[31], req.a};
        cnt_next = cnt_reg;
        ph_next = ph_reg;
        acc_next = acc_reg;
        mag_next = mag_reg;
        mul_next = mul_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        neg_next = neg_reg;
        a_next = a_reg;
        done_next = 1'b0;
        trial = '0;
        sum = '0;
        unique case (ph_reg)
            2'd0:
            begin
                if (req.start)
                begin
                    neg_next = d[32];
                    mag_next = d[32] ? (~d + 33'd1) : d;
                    mul_next = req.num;
                    den_next = req.den;
                    a_next = req.a;
                    acc_next = {34'd0, req.den[31:1]};
                    cnt_next = '0;
                    ph_next = 2'd1;
                end
            end
            2'd1:
            begin
                // One multiplier bit per cycle, rounding bias preloaded.
                if (mul_reg[cnt_reg[4:0]])
                begin
                    acc_next = acc_reg + ({32'd0, mag_reg} << cnt_reg[4:0]);
                end
                if (cnt_reg == 6'd31)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    quo_next = acc_next;
                    ph_next = 2'd2;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            2'd2:
            begin
                // One quotient bit per cycle; the quotient fits 33 bits but take all 65.
                trial = {rem_reg, quo_reg[64]} - {34'd0, den_reg};
                if (!trial[65])
                begin
                    rem_next = trial[64:0];
                    quo_next = {quo_reg[63:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[63:0], quo_reg[64]};
                    quo_next = {quo_reg[63:0], 1'b0};
                end
                if (cnt_reg == 6'd63)
                begin
                    ph_next = 2'd3;
                end
                cnt_next = cnt_reg + 6'd1;
            end
            default:
            begin
                trial = {rem_reg, quo_reg[64]} - {34'd0, den_reg};
                if (!trial[65])
                begin
                    quo_next = {quo_reg[63:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[63:0], 1'b0};
                end
                sum = neg_reg ? (a_reg - quo_next[31:0]) : (a_reg + quo_next[31:0]);
                acc_next = {33'd0, sum};
                done_next = 1'b1;
                ph_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= 2'd0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            ph_reg <= ph_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mag_reg <= mag_next;
        mul_reg <= mul_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
        a_reg <= a_next;
    end

    assign done = done_reg;
    assign res = acc_reg[31:0];
endmodule
`default_nettype wire

/* design/track_point_interpolator.sv */
// Track point interpolator: a load scans the table for the insert position and shifts the
// later entries up by one before the new point is written.
// A tick reads consecutive table entries, one per cycle, to find the bracketing segment, then
// runs the x and y lerps through one shared multiply/divide unit. One transaction is handled
// at a time.
// Reset clears the point count, second counter and stop flag; the table itself is not cleared.
`default_nettype none
module track_point_interpolator (
    input  wire logic clk,
    input  wire logic rst_n,
    tpi_stream_if.sink   in_ch,
    tpi_stream_if.source out_ch
);
    import tpi_pkg::*;

    state_t        state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [23:0]   sec_reg, sec_next;
    logic          stop_reg, stop_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    item_t         item_reg, item_next;
    point_t        prev_reg, prev_next;
    point_t        hold_reg, hold_next;
    result_t       res_reg, res_next;
    result_t       out_reg, out_next;
    logic          ovalid_reg, ovalid_next;
    logic          past_reg, past_next;
    logic          we;
    logic [IDX_W-1:0] addr;
    point_t        wdata, rdata;
    lerp_req_t     lreq;
    logic          ldone;
    logic [31:0]   lres;
    logic [31:0]   tnow;
    item_t         in_item;

    assign in_item = item_t'(in_ch.data);
    assign tnow = {sec_reg, 8'd0};

    tpi_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    tpi_lerp u_lerp (.clk(clk), .rst_n(rst_n), .req(lreq), .done(ldone), .res(lres));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sec_next = sec_reg;
        stop_next = stop_reg;
        idx_next = idx_reg;
        item_next = item_reg;
        prev_next = prev_reg;
        hold_next = hold_reg;
        res_next = res_reg;
        out_next = out_reg;
        past_next = past_reg;
        ovalid_next = ovalid_reg;
        if (out_ch.valid && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next = in_item;
                    idx_next = '0;
                    if (in_item.command == CMD_LOAD)
                    begin
                        hold_next = point_t'{in_item.point_time, in_item.point_x,
                                             in_item.point_y};
                        if (count_reg != CNT_W'(MAX_POINTS))
                        begin
                            state_next = ST_LSCAN;
                        end
                    end
                    else if (count_reg != '0 && !stop_reg)
                    begin
                        if (sec_reg != SECOND_MAX)
                        begin
                            sec_next = sec_reg + 24'd1;
                        end
                        state_next = ST_TRD;
                    end
                end
            end
            ST_LSCAN:
            begin
                // Find the insert position: first entry with time above the new one.
                if (idx_reg == count_reg)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    state_next = ST_LCHK;
                end
            end
            ST_LCHK:
            begin
                if (rdata.t <= item_reg.point_time)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    state_next = ST_LSCAN;
                end
                else
                begin
                    // Shift entries from idx up by one, front to back; hold carries the
                    // entry that goes into the current slot.
                    state_next = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR:
            begin
                // The old entry at idx was read the cycle before and is displaced now.
                idx_next = idx_reg + CNT_W'(1);
                hold_next = rdata;
                if (idx_reg + CNT_W'(1) == count_reg)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = ST_SHIFT_WR;
            end
            ST_INSERT:
            begin
                count_next = count_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_TRD:
            begin
                state_next = ST_TCHK;
                prev_next = rdata;
                res_next.final_tick = 1'b0;
                if (idx_reg == '0)
                begin
                    past_next = 1'b1;
                end
            end
            ST_TCHK:
            begin
                // rdata holds entry idx; prev holds entry idx-1.
                if (idx_reg != '0 && past_reg && tnow >= prev_reg.t && tnow <= rdata.t)
                begin
                    past_next = 1'b0;
                    hold_next = rdata;
                    if (prev_reg.t == rdata.t)
                    begin
                        res_next.pos_x = prev_reg.x;
                        res_next.pos_y = prev_reg.y;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_LX;
                    end
                end
                else if (idx_reg + CNT_W'(1) == count_reg)
                begin
                    res_next.pos_x = rdata.x;
                    res_next.pos_y = rdata.y;
                    state_next = ST_OUT;
                end
                else
                begin
                    prev_next = rdata;
                    idx_next = idx_reg + CNT_W'(1);
                    state_next = ST_TCHK;
                end
                if (idx_reg + CNT_W'(1) == count_reg)
                begin
                    res_next.final_tick = tnow > rdata.t;
                end
                else
                begin
                    hold_next = (past_next == 1'b0) ? rdata : hold_reg;
                end
            end
            ST_LX:
            begin
                if (ldone)
                begin
                    res_next.pos_x = lres;
                    state_next = ST_LY;
                end
            end
            ST_LY:
            begin
                if (ldone)
                begin
                    res_next.pos_y = lres;
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                if (!ovalid_reg)
                begin
                    out_next.elapsed_seconds = sec_reg;
                    out_next.pos_x = res_reg.pos_x;
                    out_next.pos_y = res_reg.pos_y;
                    out_next.past_end = past_reg;
                    out_next.final_tick = res_reg.final_tick;
                    ovalid_next = 1'b1;
                    if (res_reg.final_tick)
                    begin
                        stop_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Memory port and lerp request decode.
    logic lx_go_reg, ly_go_reg;
    always_comb
    begin
        we = 1'b0;
        addr = idx_reg[IDX_W-1:0];
        wdata = hold_reg;
        lreq = '0;
        lreq.num = tnow - prev_reg.t;
        lreq.den = hold_reg.t - prev_reg.t;
        lreq.a = (state_reg == ST_LY) ? prev_reg.y : prev_reg.x;
        lreq.b = (state_reg == ST_LY) ? hold_reg.y : hold_reg.x;
        lreq.start = lx_go_reg || ly_go_reg;
        unique case (state_reg)
            ST_SHIFT_WR, ST_INSERT:
            begin
                we = 1'b1;
            end
            ST_SHIFT_RD:
            begin
                addr = idx_reg[IDX_W-1:0];
            end
            ST_TCHK:
            begin
                addr = IDX_W'(idx_reg + CNT_W'(1));
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            sec_reg <= '0;
            stop_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            lx_go_reg <= 1'b0;
            ly_go_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sec_reg <= sec_next;
            stop_reg <= stop_next;
            ovalid_reg <= ovalid_next;
            lx_go_reg <= (state_reg != ST_LX) && (state_next == ST_LX);
            ly_go_reg <= (state_reg == ST_LX) && (state_next == ST_LY);
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        item_reg <= item_next;
        prev_reg <= prev_next;
        hold_reg <= hold_next;
        res_reg <= res_next;
        out_reg <= out_next;
        past_reg <= (state_reg == ST_IDLE) ? 1'b1 : past_next;
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = out_reg;
endmodule
`default_nettype wire

/* design/tpi_checker.sv */
// Port-level assertions for the track point interpolator, bound to the top level.
`default_nettype none
module tpi_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [89:0] out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_ctrl_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}))
        else $error("handshake output unknown");
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(out_data))
        else $error("result transaction carries unknown bits");
    a_past_not_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data[0] |-> out_data[1])
        else $error("final tick without past end");
endmodule

bind track_point_interpolator tpi_checker u_tpi_checker (
    .clk(clk), .rst_n(rst_n),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench of the track point interpolator with a built-in path predictor.
`default_nettype none
module testbench;
    import tpi_pkg::*;

    localparam int PAD_CYCLES = 2 * MAX_POINTS + 20;

    logic clk;
    logic rst_n;

    tpi_stream_if #(.W($bits(item_t)))   in_ch ();
    tpi_stream_if #(.W($bits(result_t))) out_ch ();

    track_point_interpolator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predictor copy of the point table and run state.
    logic [31:0] path_t [MAX_POINTS];
    logic [31:0] path_x [MAX_POINTS];
    logic [31:0] path_y [MAX_POINTS];
    int          path_len;
    logic [23:0] sec_count;
    logic        stopped;

    item_t   pending_items[$];
    result_t expected_positions[$];
    int      error_count;
    bit      stim_done;
    bit      send_paused;
    bit      in_fire;
    int      hold_off_cycles;
    int      send_gap;
    int      recv_gap;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] lerp_one(logic [31:0] a, logic [31:0] b,
                                             logic [31:0] num, logic [31:0] den);
        longint sa;
        longint sb;
        longint d;
        longint unsigned mag;
        longint unsigned q;
        longint r;
        sa = longint'(signed'(a));
        sb = longint'(signed'(b));
        d = sb - sa;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = (mag * longint'(num) + longint'(den / 2)) / longint'(den);
        r = (d < 0) ? sa - longint'(q) : sa + longint'(q);
        return r[31:0];
    endfunction

    // Applies one accepted transaction to the predictor.
    task automatic predict_position(item_t it);
        int pos;
        int last;
        longint unsigned tq;
        logic [31:0] px;
        logic [31:0] py;
        logic past;
        result_t res;
        if (it.command == CMD_LOAD)
        begin
            if (path_len >= MAX_POINTS)
                return;
            pos = 0;
            while (pos < path_len && path_t[pos] <= it.point_time)
                pos++;
            for (int i = path_len; i > pos; i--)
            begin
                path_t[i] = path_t[i-1];
                path_x[i] = path_x[i-1];
                path_y[i] = path_y[i-1];
            end
            path_t[pos] = it.point_time;
            path_x[pos] = it.point_x;
            path_y[pos] = it.point_y;
            path_len++;
            return;
        end
        if (path_len == 0 || stopped)
            return;
        if (sec_count != SECOND_MAX)
            sec_count++;
        tq = longint'(sec_count) << 8;
        last = path_len - 1;
        px = path_x[last];
        py = path_y[last];
        past = 1'b1;
        for (int i = 0; i + 1 < path_len; i++)
        begin
            if (tq >= path_t[i] && tq <= path_t[i+1])
            begin
                if (path_t[i] == path_t[i+1])
                begin
                    px = path_x[i];
                    py = path_y[i];
                end
                else
                begin
                    px = lerp_one(path_x[i], path_x[i+1], 32'(tq - path_t[i]),
                                  path_t[i+1] - path_t[i]);
                    py = lerp_one(path_y[i], path_y[i+1], 32'(tq - path_t[i]),
                                  path_t[i+1] - path_t[i]);
                end
                past = 1'b0;
                break;
            end
        end
        res.elapsed_seconds = sec_count;
        res.pos_x = px;
        res.pos_y = py;
        res.past_end = past;
        res.final_tick = (tq > path_t[last]);
        if (res.final_tick)
            stopped = 1'b1;
        expected_positions.push_back(res);
    endtask

    function automatic item_t make_load(logic [31:0] t, logic [31:0] x, logic [31:0] y);
        item_t it;
        it.command = CMD_LOAD;
        it.point_time = t;
        it.point_x = x;
        it.point_y = y;
        return it;
    endfunction

    function automatic item_t make_tick();
        item_t it;
        it.command = CMD_TICK;
        it.point_time = $urandom;
        it.point_x = $urandom;
        it.point_y = $urandom;
        return it;
    endfunction

    // Driver: offers queued transactions at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else if (in_ch.valid && !in_fire)
        begin
            // hold the offered transaction
        end
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            in_ch.valid <= 1'b0;
        end
        else if (!send_paused && pending_items.size() > 0)
        begin
            in_ch.data <= pending_items.pop_front();
            in_ch.valid <= 1'b1;
            send_gap <= gap_length();
        end
        else
        begin
            in_ch.valid <= 1'b0;
        end
    end

    // Predictor fed by accepted input transactions.
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
            predict_position(item_t'(in_ch.data));
    end

    // Receiver readiness with random stalls and one forced long hold-off.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            recv_gap <= gap_length();
        end
    end

    // Monitor and checker.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = result_t'(out_ch.data);
            if (expected_positions.size() == 0)
            begin
                $error("unexpected result transaction");
                error_count++;
            end
            else
            begin
                want = expected_positions.pop_front();
                if (got.elapsed_seconds !== want.elapsed_seconds)
                begin
                    $error("elapsed_seconds: expected %0d, got %0d",
                           want.elapsed_seconds, got.elapsed_seconds);
                    error_count++;
                end
                if (got.pos_x !== want.pos_x)
                begin
                    $error("pos_x: expected %h, got %h", want.pos_x, got.pos_x);
                    error_count++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $error("pos_y: expected %h, got %h", want.pos_y, got.pos_y);
                    error_count++;
                end
                if (got.past_end !== want.past_end)
                begin
                    $error("past_end: expected %b, got %b", want.past_end, got.past_end);
                    error_count++;
                end
                if (got.final_tick !== want.final_tick)
                begin
                    $error("final_tick: expected %b, got %b",
                           want.final_tick, got.final_tick);
                    error_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_ch.valid || expected_positions.size() > 0)
            @(posedge clk);
    endtask

    task automatic reset_predictor();
        path_len = 0;
        sec_count = '0;
        stopped = 1'b0;
    endtask

    // Queues one random path: mostly sorted-ish points with nearby times, then ticks.
    task automatic queue_random_path(int n_points, int n_ticks);
        logic [31:0] base;
        logic [31:0] tt;
        base = $urandom_range(0, 4) << 8;
        for (int i = 0; i < n_points; i++)
        begin
            case ($urandom_range(0, 5))
                0: tt = base;
                1: tt = $urandom;
                default: tt = base + $urandom_range(0, 2000);
            endcase
            base = tt;
            if ($urandom_range(0, 3) == 0)
                pending_items.push_back(make_load(tt, $urandom, $urandom));
            else
                pending_items.push_back(make_load(tt, $urandom_range(0, 200000) - 100000,
                                                  $urandom_range(0, 200000) - 100000));
        end
        for (int i = 0; i < n_ticks; i++)
            pending_items.push_back(make_tick());
    endtask

    // The table only empties at reset, so each phase appends to it; once it is
    // full, later loads are dropped and the ticks keep walking the same path.
    initial
    begin
        error_count = 0;
        stim_done = 1'b0;
        send_paused = 1'b0;
        hold_off_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        reset_predictor();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: a tick on an empty table, then extremes and equal times.
        pending_items.push_back(make_tick());
        pending_items.push_back(make_load(32'h0000_0300, 32'h8000_0000, 32'h7FFF_FFFF));
        pending_items.push_back(make_load(32'h0000_0100, 32'h7FFF_FFFF, 32'h8000_0000));
        pending_items.push_back(make_load(32'h0000_0100, 32'h0001_0000, 32'hFFFF_0000));
        pending_items.push_back(make_load(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        pending_items.push_back(make_load(32'h0000_0280, 32'h0000_0003, 32'hFFFF_FFFD));
        pending_items.push_back(make_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_tick());
        // Receiver holds off while the sender keeps offering.
        hold_off_cycles = 3000;
        wait_drained();

        // One more point is inserted in the middle of the existing path.
        while (hold_off_cycles > 0)
            @(posedge clk);
        reset_after_phase();
        pending_items.push_back(make_load(32'h0000_0500, 32'h1234_5678, 32'h8765_4321));
        for (int i = 0; i < 7; i++)
            pending_items.push_back(make_tick());
        wait_drained();

        // Full table: extra loads are ignored; once drained, the sender is paused and then resumed.
        reset_after_phase();
        for (int i = 0; i < MAX_POINTS + 3; i++)
            pending_items.push_back(make_load(i << 8, $urandom, $urandom));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_tick());
        wait_drained();
        send_paused = 1'b1;
        repeat (20) @(posedge clk);
        send_paused = 1'b0;

        // Random paths.
        for (int k = 0; k < 33; k++)
        begin
            reset_after_phase();
            queue_random_path($urandom_range(1, 10), $urandom_range(5, 20));
            wait_drained();
        end

        // Counter saturation: a point far in the future and many ticks would be
        // too slow, so only the first seconds of a very long path are covered.
        reset_after_phase();
        pending_items.push_back(make_load(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        pending_items.push_back(make_load(32'hFFFF_FF00, 32'h7FFF_FFFF, 32'h8000_0000));
        for (int i = 0; i < 10; i++)
            pending_items.push_back(make_tick());
        wait_drained();

        stim_done = 1'b1;
        repeat (PAD_CYCLES + 200) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Starting a new path needs an empty table, which only reset gives, so
    // each phase instead appends points; the predictor tracks that exactly.
    task automatic reset_after_phase();
        repeat (PAD_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
